// ===== hdl/mic_pkg.sv =====
// Shared types and constants for the mesh index compaction block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mic_pkg;

    localparam int unsigned IDX_W   = 12;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned SRC_W   = 16;
    localparam int unsigned GEN_W   = 8;
    localparam int unsigned ENTRY_W = GEN_W + IDX_W;
    localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
    localparam logic [GEN_W-1:0] GEN_LAST  = '1;
    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(4096);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_READ,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic load;
        logic reread;
        logic sweep;
        logic sweep_done;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic wrap;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/mic_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the remap table.
`default_nettype none

module mic_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/mic_ctrl.sv =====
// Sequencing state machine for the mesh index compaction block.
// Depends on mic_pkg; drives the datapath through command and status structs.
`default_nettype none

module mic_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire mic_pkg::t_dp_sts  i_sts,
    output mic_pkg::t_dp_cmd       o_cmd,
    output logic                   o_s_tready
);

    import mic_pkg::*;

    t_state r_state, n_state;
    logic   r_pending, n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.sweep_done = 1'b1;
                    n_pending        = 1'b0;
                    n_state          = r_pending ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.reread = 1'b1;
                n_state      = ST_LOOKUP;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.wrap) begin
                        n_pending = 1'b1;
                        n_state   = ST_SWEEP;
                    end else begin
                        n_state = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mic_datapath.sv =====
// Datapath: remap table with generation tags, unique counter and result register.
// Depends on mic_pkg and mic_ram; steered by mic_ctrl.
`default_nettype none

module mic_datapath #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mic_pkg::t_dp_cmd          i_cmd,
    output mic_pkg::t_dp_sts               o_sts,
    input  wire logic [mic_pkg::CNT_W-1:0] i_vertex_count,
    input  wire logic                      i_group_start,
    input  wire logic [mic_pkg::SRC_W-1:0] i_source_index,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [mic_pkg::IDX_W-1:0]      o_new_index,
    output logic                           o_first_use,
    output logic [mic_pkg::CNT_W-1:0]      o_unique_count,
    output logic                           o_out_of_range
);

    import mic_pkg::*;

    localparam int unsigned AW    = $clog2(MAX_VERTICES);
    localparam int unsigned LIM_W = SRC_W + 1;

    logic [SRC_W-1:0]   r_src;
    logic [GEN_W-1:0]   r_gen;
    logic [CNT_W-1:0]   r_count;
    logic [AW-1:0]      r_sweep_addr;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_new_index;
    logic               r_first_use;
    logic [CNT_W-1:0]   r_unique_count;
    logic               r_out_of_range;

    logic [ENTRY_W-1:0] w_rdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [LIM_W-1:0]   w_vc_ext;
    logic [LIM_W-1:0]   w_limit;
    logic               w_oor;
    logic               w_hit;
    logic               w_assign;
    logic [CNT_W-1:0]   w_count_inc;

    assign w_vc_ext    = LIM_W'(i_vertex_count);
    assign w_limit     = (w_vc_ext > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES) : w_vc_ext;
    assign w_oor       = {1'b0, r_src} >= w_limit;
    assign w_hit       = w_rdata[ENTRY_W-1 -: GEN_W] == r_gen;
    assign w_assign    = i_cmd.commit && !w_oor && !w_hit;
    assign w_count_inc = r_count + CNT_W'(1);

    assign w_re    = i_cmd.load || i_cmd.reread;
    assign w_raddr = i_cmd.load ? i_source_index[AW-1:0] : r_src[AW-1:0];
    assign w_we    = i_cmd.sweep || w_assign;
    assign w_waddr = i_cmd.sweep ? r_sweep_addr : r_src[AW-1:0];
    assign w_wdata = i_cmd.sweep ? '0 : {r_gen, r_count[IDX_W-1:0]};

    mic_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= GEN_FIRST;
            r_count      <= '0;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sweep_done) begin
                r_gen        <= GEN_FIRST;
                r_count      <= '0;
                r_sweep_addr <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
            if (i_cmd.load && i_group_start && !o_sts.wrap) begin
                r_gen   <= r_gen + GEN_W'(1);
                r_count <= '0;
            end
            if (w_assign) begin
                r_count <= w_count_inc;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src <= i_source_index;
        end
        if (i_cmd.commit) begin
            r_out_of_range <= w_oor;
            if (w_oor) begin
                r_new_index    <= '0;
                r_first_use    <= 1'b0;
                r_unique_count <= '0;
            end else if (w_hit) begin
                r_new_index    <= w_rdata[IDX_W-1:0];
                r_first_use    <= 1'b0;
                r_unique_count <= r_count;
            end else begin
                r_new_index    <= r_count[IDX_W-1:0];
                r_first_use    <= 1'b1;
                r_unique_count <= w_count_inc;
            end
        end
    end

    assign o_sts.wrap       = i_group_start && (r_gen == GEN_LAST);
    assign o_sts.sweep_last = r_sweep_addr == AW'(MAX_VERTICES - 1);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_new_index    = r_new_index;
    assign o_first_use    = r_first_use;
    assign o_unique_count = r_unique_count;
    assign o_out_of_range = r_out_of_range;

endmodule

`default_nettype wire

// ===== hdl/mesh_index_compaction.sv =====
// Top level of the mesh index compaction block: stream ports, register port, checks.
// Depends on mic_pkg, mic_ctrl and mic_datapath.
//
// Each source index beat is handled as a read of its remap table entry, followed by an
// update of the entry and the registering of the result, as the table has one read and
// one write port with registered read data. The result is registered only while the
// result register is free or being drained, and the next beat is not accepted before
// that. Groups are told apart by a generation tag held in each table entry, so a group
// start costs nothing, except that every 255th group start triggers a sweep that rewrites
// every tag, followed by a second read of that beat's entry. After reset the same sweep
// runs before the first beat is accepted.
`default_nettype none

module mesh_index_compaction #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // source_index
    input  wire logic        i_s_tuser,   // group_start
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // new_index, unique_count, zero padding
    output logic [1:0]       o_m_tuser,   // first_use, out_of_range
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    import mic_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [CNT_W-1:0] r_vertex_count;
    logic [IDX_W-1:0] w_new_index;
    logic             w_first_use;
    logic [CNT_W-1:0] w_unique_count;
    logic             w_out_of_range;
    logic             w_reg_sel;

    assign o_pready  = 1'b1;
    assign w_reg_sel = !i_paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_reg_sel) begin
            r_vertex_count <= i_pwdata[CNT_W-1:0];
        end
    end

    assign o_prdata = w_reg_sel ? 32'(r_vertex_count) : '0;

    mic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready)
    );

    mic_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_vertex_count (r_vertex_count),
        .i_group_start  (i_s_tuser),
        .i_source_index (i_s_tdata),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_new_index    (w_new_index),
        .o_first_use    (w_first_use),
        .o_unique_count (w_unique_count),
        .o_out_of_range (w_out_of_range)
    );

    assign o_m_tdata = {7'b0, w_unique_count, w_new_index};
    assign o_m_tuser = {w_out_of_range, w_first_use};

    a_commit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_sts.out_free)
        else $error("result committed over an untaken result");

    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second beat accepted before the first was handled");

    a_oor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == 32'd0 && !o_m_tuser[0]))
        else $error("out of range result carries non-zero fields");

    a_first_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[23:12] == o_m_tdata[11:0] + 12'd1))
        else $error("first use does not match the unique count");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mesh_index_compaction: streams grouped source indices through
// the block at random rates, predicts every compact index and checks each result beat.
// Depends on mic_pkg and the mesh_index_compaction RTL.

module tb;
    import mic_pkg::*;

    localparam int unsigned MAX_VERTS   = 4096;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE      = 16;
    localparam logic [2:0]  REG_VERTEX_COUNT = 3'd0;

    typedef struct packed {
        logic [IDX_W-1:0] new_index;
        logic             first_use;
        logic [CNT_W-1:0] unique_count;
        logic             out_of_range;
    } t_remap_result;

    class t_compaction_scoreboard;
        t_remap_result    expected_remaps[$];
        logic [IDX_W-1:0] remap[MAX_VERTS];
        int unsigned      owner_group[MAX_VERTS];
        int unsigned      group_id;
        logic [CNT_W-1:0] unique_count;
        logic [CNT_W-1:0] vertex_count;
        int unsigned      errors;

        function new();
            foreach (owner_group[i]) owner_group[i] = 0;
            group_id     = 1;
            unique_count = '0;
            vertex_count = VCOUNT_RESET;
            errors       = 0;
        endfunction

        function void set_vertex_count(logic [CNT_W-1:0] value);
            vertex_count = value;
        endfunction

        function int unsigned index_limit();
            return (vertex_count > MAX_VERTS) ? MAX_VERTS : int'(vertex_count);
        endfunction

        function int unsigned pending();
            return expected_remaps.size();
        endfunction

        function void note_source(logic start, logic [SRC_W-1:0] src);
            t_remap_result r;
            if (start) begin
                group_id++;
                unique_count = '0;
            end
            r = '0;
            if (src >= index_limit()) begin
                r.out_of_range = 1'b1;
            end else if (owner_group[src] == group_id) begin
                r.new_index    = remap[src];
                r.unique_count = unique_count;
            end else begin
                owner_group[src] = group_id;
                remap[src]       = unique_count[IDX_W-1:0];
                r.new_index      = unique_count[IDX_W-1:0];
                r.first_use      = 1'b1;
                unique_count     = unique_count + 1'b1;
                r.unique_count   = unique_count;
            end
            expected_remaps.insert(expected_remaps.size(), r);
        endfunction

        function void check_result(logic [31:0] tdata, logic [1:0] tuser);
            t_remap_result got;
            t_remap_result exp;
            got.new_index    = tdata[IDX_W-1:0];
            got.unique_count = tdata[IDX_W+CNT_W-1:IDX_W];
            got.first_use    = tuser[0];
            got.out_of_range = tuser[1];
            if (expected_remaps.size() == 0) begin
                $display("%0t: result beat with nothing expected: new_index %0d first_use %0b",
                         $time, got.new_index, got.first_use);
                errors++;
                return;
            end
            exp = expected_remaps.pop_front();
            if (got.new_index !== exp.new_index) begin
                $display("%0t: new_index expected %0d, got %0d",
                         $time, exp.new_index, got.new_index);
                errors++;
            end
            if (got.first_use !== exp.first_use) begin
                $display("%0t: first_use expected %0b, got %0b",
                         $time, exp.first_use, got.first_use);
                errors++;
            end
            if (got.unique_count !== exp.unique_count) begin
                $display("%0t: unique_count expected %0d, got %0d",
                         $time, exp.unique_count, got.unique_count);
                errors++;
            end
            if (got.out_of_range !== exp.out_of_range) begin
                $display("%0t: out_of_range expected %0b, got %0b",
                         $time, exp.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // source_index
    logic        i_s_tuser;   // group_start
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // new_index, unique_count, zero padding
    logic [1:0]  o_m_tuser;   // first_use, out_of_range
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    t_compaction_scoreboard sb = new();
    bit                     send_bursty;
    bit                     recv_bursty;
    int unsigned            cycle_count;

    mesh_index_compaction #(.MAX_VERTICES(MAX_VERTS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(input logic start, input logic [SRC_W-1:0] src);
        int unsigned gap;
        gap = send_bursty ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = start;
        i_s_tdata  = src;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_source(start, src);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_drained();
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = REG_VERTEX_COUNT;
        i_pwdata  = 32'(value);
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.set_vertex_count(value);
        @(negedge i_clk);
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== 32'(value)) begin
            $display("%0t: vertex_count read back expected %0d, got %0d",
                     $time, value, o_prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
    endtask

    // Groups are mostly short so that many group starts occur and the tag wrap is reached.
    task automatic run_groups(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned lim;
        int unsigned base;
        int unsigned width;
        logic        start;
        logic [SRC_W-1:0] src;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 48) : $urandom_range(1, 4);
            lim   = sb.index_limit();
            width = $urandom_range(1, 16);
            base  = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
            if ($urandom_range(0, 5) == 0) send_bursty = !send_bursty;
            for (int unsigned k = 0; k < len; k++) begin
                start = (k == 0) ? ($urandom_range(0, 24) != 0) : ($urandom_range(0, 40) == 0);
                if ($urandom_range(0, 11) == 0) src = SRC_W'($urandom);
                else src = SRC_W'(base + $urandom_range(0, width - 1));
                send_beat(start, src);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        cycle_count = 0;
        send_bursty = 1'b0;
        recv_bursty = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(1'b1, 16'd0);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd4095);
        send_beat(1'b0, 16'd4095);
        send_beat(1'b0, 16'd4096);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b0, 16'hAAAA);
        send_beat(1'b0, 16'h5555);
        send_beat(1'b1, 16'd4095);
        send_beat(1'b0, 16'd0);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd1);
        send_beat(1'b0, 16'd2);
        send_beat(1'b0, 16'd1);
        write_vertex_count(13'd1);
        send_beat(1'b1, 16'd0);
        send_beat(1'b0, 16'd1);
        send_beat(1'b0, 16'd0);
        write_vertex_count(13'd8191);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd4095);
        write_vertex_count(13'd0);
        send_beat(1'b0, 16'd0);
        send_beat(1'b1, 16'd0);
        write_vertex_count(13'd4096);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd4095);

        run_groups(260);
        write_vertex_count(13'd16);
        run_groups(200);
        write_vertex_count(13'd8191);
        run_groups(200);
        write_vertex_count(13'd1);
        run_groups(100);
        write_vertex_count(13'd4095);
        run_groups(200);
        write_vertex_count(13'd2);
        run_groups(120);
        write_vertex_count(13'd0);
        run_groups(60);
        write_vertex_count(CNT_W'($urandom_range(1, 4096)));
        run_groups(200);
        write_vertex_count(13'd300);
        run_groups(200);
        write_vertex_count(13'd4096);
        run_groups(160);

        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_bursty = !recv_bursty;
            stall = recv_bursty ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            sb.check_result(o_m_tdata, o_m_tuser);
            @(negedge i_clk);
        end
    end

endmodule

// ===== sim.f =====
hdl/mic_pkg.sv
hdl/mic_ram.sv
hdl/mic_ctrl.sv
hdl/mic_datapath.sv
hdl/mesh_index_compaction.sv
tb/tb.sv
